/* hdl/ctok_pkg.sv */
`default_nettype none

package ctok_pkg;

  // position counters and the position fields of a token share this width
  localparam int PosBits = 20;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);

  localparam int KindBits = 5;

  // result queue
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // scanner modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_OP    = 2'd3;

  // token kinds
  localparam logic [KindBits-1:0] KIND_LIT     = 5'd0;
  localparam logic [KindBits-1:0] KIND_IDENT   = 5'd1;
  localparam logic [KindBits-1:0] KIND_INT     = 5'd2;
  localparam logic [KindBits-1:0] KIND_RETURN  = 5'd3;
  localparam logic [KindBits-1:0] KIND_IF      = 5'd4;
  localparam logic [KindBits-1:0] KIND_WHILE   = 5'd5;
  localparam logic [KindBits-1:0] KIND_EQ2     = 5'd6;
  localparam logic [KindBits-1:0] KIND_AND2    = 5'd7;
  localparam logic [KindBits-1:0] KIND_OR2     = 5'd8;
  localparam logic [KindBits-1:0] KIND_NE2     = 5'd9;
  localparam logic [KindBits-1:0] KIND_PLUS    = 5'd10;
  localparam logic [KindBits-1:0] KIND_MINUS   = 5'd11;
  localparam logic [KindBits-1:0] KIND_STAR    = 5'd12;
  localparam logic [KindBits-1:0] KIND_SLASH   = 5'd13;
  localparam logic [KindBits-1:0] KIND_ASSIGN  = 5'd14;
  localparam logic [KindBits-1:0] KIND_LT      = 5'd15;
  localparam logic [KindBits-1:0] KIND_GT      = 5'd16;
  localparam logic [KindBits-1:0] KIND_NOT     = 5'd17;
  localparam logic [KindBits-1:0] KIND_SEMI    = 5'd18;
  localparam logic [KindBits-1:0] KIND_LPAREN  = 5'd19;
  localparam logic [KindBits-1:0] KIND_RPAREN  = 5'd20;
  localparam logic [KindBits-1:0] KIND_LBRACE  = 5'd21;
  localparam logic [KindBits-1:0] KIND_RBRACE  = 5'd22;
  localparam logic [KindBits-1:0] KIND_UNKNOWN = 5'd23;
  localparam logic [KindBits-1:0] KIND_END     = 5'd24;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [KindBits-1:0] token_kind;
    logic [PosBits-1:0]  start_offset;
    logic [PosBits-1:0]  token_length;
    logic [PosBits-1:0]  line_number;
    logic [PosBits-1:0]  column_number;
    logic                last;
  } out_item_t;

  // results produced by one item, first in res0
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } push_t;

endpackage

`default_nettype wire

/* hdl/ctok_lexer.sv */
`default_nettype none

module ctok_lexer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  ctok_pkg::in_item_t     item_i,
  output ctok_pkg::push_t        push_o
);

  logic [1:0]                   mode_q, mode_d;
  logic [7:0]                   pend_q, pend_d;
  logic [ctok_pkg::PosBits-1:0] tok_start_q, tok_start_d;
  logic [ctok_pkg::PosBits-1:0] tok_line_q, tok_line_d;
  logic [ctok_pkg::PosBits-1:0] tok_col_q, tok_col_d;
  logic [ctok_pkg::PosBits-1:0] cur_off_q, cur_off_d;
  logic [ctok_pkg::PosBits-1:0] cur_line_q, cur_line_d;
  logic [ctok_pkg::PosBits-1:0] cur_col_q, cur_col_d;
  logic [3:0]                   hits_q, hits_d;
  logic [2:0]                   id_len_q, id_len_d;

  function automatic logic [ctok_pkg::PosBits-1:0] sat_inc(
    input logic [ctok_pkg::PosBits-1:0] v
  );
    return (v == ctok_pkg::PosMax) ? v : v + ctok_pkg::PosOne;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    unique case (k)
      2'd0:    n = 3'd3;
      2'd1:    n = 3'd6;
      2'd2:    n = 3'd2;
      default: n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (idx)
          3'd0:    c = "i";
          3'd1:    c = "n";
          3'd2:    c = "t";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (idx)
          3'd0:    c = "r";
          3'd1:    c = "e";
          3'd2:    c = "t";
          3'd3:    c = "u";
          3'd4:    c = "r";
          3'd5:    c = "n";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (idx)
          3'd0:    c = "i";
          3'd1:    c = "f";
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    c = "w";
          3'd1:    c = "h";
          3'd2:    c = "i";
          3'd3:    c = "l";
          3'd4:    c = "e";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [3:0] take_hits(
    input logic [3:0] hits, input logic [2:0] len, input logic [7:0] c
  );
    logic [3:0] h;
    h = hits;
    for (int k = 0; k < 4; k++) begin
      if (len >= kw_len(2'(k)) || kw_char(2'(k), len) != c) begin
        h[k] = 1'b0;
      end
    end
    return h;
  endfunction

  function automatic logic [ctok_pkg::KindBits-1:0] single_kind(input logic [7:0] c);
    logic [ctok_pkg::KindBits-1:0] kd;
    unique case (c)
      "+":     kd = ctok_pkg::KIND_PLUS;
      "-":     kd = ctok_pkg::KIND_MINUS;
      "*":     kd = ctok_pkg::KIND_STAR;
      "/":     kd = ctok_pkg::KIND_SLASH;
      "=":     kd = ctok_pkg::KIND_ASSIGN;
      "<":     kd = ctok_pkg::KIND_LT;
      ">":     kd = ctok_pkg::KIND_GT;
      "!":     kd = ctok_pkg::KIND_NOT;
      ";":     kd = ctok_pkg::KIND_SEMI;
      "(":     kd = ctok_pkg::KIND_LPAREN;
      ")":     kd = ctok_pkg::KIND_RPAREN;
      "{":     kd = ctok_pkg::KIND_LBRACE;
      "}":     kd = ctok_pkg::KIND_RBRACE;
      default: kd = ctok_pkg::KIND_UNKNOWN;
    endcase
    return kd;
  endfunction

  function automatic ctok_pkg::out_item_t mk_res(
    input logic [ctok_pkg::KindBits-1:0] kind,
    input logic [ctok_pkg::PosBits-1:0]  start,
    input logic [ctok_pkg::PosBits-1:0]  len,
    input logic [ctok_pkg::PosBits-1:0]  line,
    input logic [ctok_pkg::PosBits-1:0]  col
  );
    ctok_pkg::out_item_t r;
    r.token_kind    = kind;
    r.start_offset  = start;
    r.token_length  = len;
    r.line_number   = line;
    r.column_number = col;
    r.last          = 1'b0;
    return r;
  endfunction

  logic [7:0] c;
  logic       is_digit, is_alpha, is_space, is_ident, is_opstart;
  logic       flush_present, new_present, consume, pair_hit;
  logic [ctok_pkg::KindBits-1:0] ident_kind, flush_kind, pair_kind;
  ctok_pkg::out_item_t flush_res, single_res, end_res, pair_res;

  assign c          = item_i.ch;
  assign is_digit   = (c >= "0") && (c <= "9");
  assign is_alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_space   = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign is_ident   = is_alpha || is_digit || (c == "_");
  assign is_opstart = (c == "=") || (c == "&") || (c == "|") || (c == "!");

  // first keyword that still matches at the exact length wins
  always_comb begin
    ident_kind = ctok_pkg::KIND_IDENT;
    for (int k = 3; k >= 0; k--) begin
      if (hits_q[k] && id_len_q == kw_len(2'(k))) begin
        ident_kind = ctok_pkg::KIND_INT + ctok_pkg::KindBits'(k);
      end
    end
  end

  always_comb begin
    pair_hit  = 1'b1;
    pair_kind = ctok_pkg::KIND_EQ2;
    priority if (pend_q == "=" && c == "=") begin
      pair_kind = ctok_pkg::KIND_EQ2;
    end else if (pend_q == "&" && c == "&") begin
      pair_kind = ctok_pkg::KIND_AND2;
    end else if (pend_q == "|" && c == "|") begin
      pair_kind = ctok_pkg::KIND_OR2;
    end else if (pend_q == "!" && c == "=") begin
      pair_kind = ctok_pkg::KIND_NE2;
    end else begin
      pair_hit = 1'b0;
    end
  end

  always_comb begin
    unique case (mode_q)
      ctok_pkg::MODE_NUM:   flush_kind = ctok_pkg::KIND_LIT;
      ctok_pkg::MODE_IDENT: flush_kind = ident_kind;
      default:              flush_kind = single_kind(pend_q);
    endcase
  end

  assign flush_present = (mode_q != ctok_pkg::MODE_IDLE);
  assign flush_res = mk_res(flush_kind, tok_start_q,
                            (mode_q == ctok_pkg::MODE_OP) ? ctok_pkg::PosOne
                                                          : cur_off_q - tok_start_q,
                            tok_line_q, tok_col_q);
  assign single_res = mk_res(single_kind(c), cur_off_q, ctok_pkg::PosOne,
                             cur_line_q, cur_col_q);
  assign end_res    = mk_res(ctok_pkg::KIND_END, cur_off_q, '0, cur_line_q, cur_col_q);
  assign pair_res   = mk_res(pair_kind, tok_start_q, ctok_pkg::PosBits'(2),
                             tok_line_q, tok_col_q);

  assign consume  = ((mode_q == ctok_pkg::MODE_NUM) && is_digit)
                 || ((mode_q == ctok_pkg::MODE_IDENT) && is_ident);
  assign new_present = !is_space && !is_digit && !is_alpha && (c != "_") && !is_opstart;

  always_comb begin
    logic [ctok_pkg::PosBits-1:0] adv_off, adv_line, adv_col;

    mode_d      = mode_q;
    pend_d      = pend_q;
    tok_start_d = tok_start_q;
    tok_line_d  = tok_line_q;
    tok_col_d   = tok_col_q;
    cur_off_d   = cur_off_q;
    cur_line_d  = cur_line_q;
    cur_col_d   = cur_col_q;
    hits_d      = hits_q;
    id_len_d    = id_len_q;
    push_o      = '0;

    // position after this byte
    adv_off  = sat_inc(cur_off_q);
    adv_line = (c == 8'h0a) ? sat_inc(cur_line_q) : cur_line_q;
    adv_col  = (c == 8'h0a) ? ctok_pkg::PosOne : sat_inc(cur_col_q);

    if (fire_i) begin
      if (item_i.end_of_input) begin
        // flush, end token, then back to the start of a fresh text
        if (flush_present) begin
          push_o.res0      = flush_res;
          push_o.res1      = end_res;
          push_o.res1.last = 1'b1;
          push_o.count     = 2'd2;
        end else begin
          push_o.res0      = end_res;
          push_o.res0.last = 1'b1;
          push_o.count     = 2'd1;
        end
        mode_d      = ctok_pkg::MODE_IDLE;
        pend_d      = 8'h00;
        tok_start_d = '0;
        tok_line_d  = ctok_pkg::PosOne;
        tok_col_d   = ctok_pkg::PosOne;
        cur_off_d   = '0;
        cur_line_d  = ctok_pkg::PosOne;
        cur_col_d   = ctok_pkg::PosOne;
        hits_d      = 4'hF;
        id_len_d    = 3'd0;
      end else begin
        cur_off_d  = adv_off;
        cur_line_d = adv_line;
        cur_col_d  = adv_col;
        if (consume) begin
          if (mode_q == ctok_pkg::MODE_IDENT) begin
            hits_d   = take_hits(hits_q, id_len_q, c);
            id_len_d = (id_len_q == 3'd7) ? id_len_q : id_len_q + 3'd1;
          end
        end else if (mode_q == ctok_pkg::MODE_OP && pair_hit) begin
          push_o.res0      = pair_res;
          push_o.res0.last = 1'b1;
          push_o.count     = 2'd1;
          mode_d           = ctok_pkg::MODE_IDLE;
        end else begin
          if (flush_present && new_present) begin
            push_o.res0      = flush_res;
            push_o.res1      = single_res;
            push_o.res1.last = 1'b1;
            push_o.count     = 2'd2;
          end else if (flush_present) begin
            push_o.res0      = flush_res;
            push_o.res0.last = 1'b1;
            push_o.count     = 2'd1;
          end else if (new_present) begin
            push_o.res0      = single_res;
            push_o.res0.last = 1'b1;
            push_o.count     = 2'd1;
          end
          mode_d = ctok_pkg::MODE_IDLE;
          if (!is_space && !new_present) begin
            tok_start_d = cur_off_q;
            tok_line_d  = cur_line_q;
            tok_col_d   = cur_col_q;
          end
          if (is_space) begin
            mode_d = ctok_pkg::MODE_IDLE;
          end else if (is_digit) begin
            mode_d = ctok_pkg::MODE_NUM;
          end else if (is_alpha || c == "_") begin
            mode_d   = ctok_pkg::MODE_IDENT;
            hits_d   = take_hits(4'hF, 3'd0, c);
            id_len_d = 3'd1;
          end else if (is_opstart) begin
            mode_d = ctok_pkg::MODE_OP;
            pend_d = c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ctok_pkg::MODE_IDLE;
      pend_q      <= 8'h00;
      tok_start_q <= '0;
      tok_line_q  <= ctok_pkg::PosOne;
      tok_col_q   <= ctok_pkg::PosOne;
      cur_off_q   <= '0;
      cur_line_q  <= ctok_pkg::PosOne;
      cur_col_q   <= ctok_pkg::PosOne;
      hits_q      <= 4'hF;
      id_len_q    <= 3'd0;
    end else begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      tok_start_q <= tok_start_d;
      tok_line_q  <= tok_line_d;
      tok_col_q   <= tok_col_d;
      cur_off_q   <= cur_off_d;
      cur_line_q  <= cur_line_d;
      cur_col_q   <= cur_col_d;
      hits_q      <= hits_d;
      id_len_q    <= id_len_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/c_subset_tokenizer_unit.sv */
`default_nettype none

// Streaming lexer for a small C subset: one source byte (or an end marker) per input
// item, tokens out as result items with kind, start offset, length, line and column.
// An input item is registered, scanned once the queue has room, and its zero, one or two
// tokens are written into a four-entry result queue that drives the output port, so
// the block takes one byte per cycle while it is not stalled, and a token can be taken
// from the output once its closing byte has been registered and scanned. The queue sets
// the rate: an item is scanned only
// while at least two entries are free, so when the output side stalls, or items that
// yield two tokens come in a long run, input is held off until the queue drains at one
// token per cycle. Numbers, identifiers and = & | ! stay pending until the next byte
// or the end item closes them; after the end token all positions start over.
module c_subset_tokenizer_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output wire logic              in_stall_o,
  input  ctok_pkg::in_item_t     in_item_i,
  output wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  output ctok_pkg::out_item_t    out_item_o
);

  // input register
  logic               s1_valid_q;
  ctok_pkg::in_item_t s1_item_q;
  logic               fire, room, in_take, pop;

  // result queue
  ctok_pkg::out_item_t           fifo_q [ctok_pkg::FifoDepth];
  logic [ctok_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [ctok_pkg::FifoCntW-1:0] count_q;
  ctok_pkg::push_t               push;

  // two free entries cover the worst case of one item
  assign room       = (count_q <= ctok_pkg::FifoCntW'(ctok_pkg::FifoDepth - 2));
  assign fire       = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  ctok_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (s1_item_q),
    .push_o (push)
  );

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nx   = wr_ptr_q + ctok_pkg::FifoPtrW'(1);

  // second token of an item lands right behind the first
  always_ff @(posedge clk_i) begin
    if (push.count != 2'd0) begin
      fifo_q[wr_ptr_q] <= push.res0;
    end
    if (push.count == 2'd2) begin
      fifo_q[wr_ptr_nx] <= push.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ctok_pkg::FifoPtrW'(push.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ctok_pkg::FifoPtrW'(1);
      end
      count_q <= count_q + ctok_pkg::FifoCntW'(push.count)
               - ctok_pkg::FifoCntW'(pop);
    end
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ctok_pkg::FifoCntW'(ctok_pkg::FifoDepth))
    else $error("result queue overflow");

  // the lexer only writes tokens for a scanned item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> push.count == 2'd0)
    else $error("tokens pushed without an item");

  // an end item always produces at least the end token, marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_item_q.end_of_input |->
      (push.count == 2'd1 && push.res0.last && push.res0.token_kind == ctok_pkg::KIND_END)
      || (push.count == 2'd2 && push.res1.last
          && push.res1.token_kind == ctok_pkg::KIND_END))
    else $error("end item without end token");

  // a popped slot is counted as gone in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !fire |=> count_q == $past(count_q) - ctok_pkg::FifoCntW'(1))
    else $error("queue count lost a pop");

  // token kinds on the output stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.token_kind <= ctok_pkg::KIND_END)
    else $error("token kind out of range");

endmodule

`default_nettype wire

/* dv/c_subset_tokenizer_unit_test.sv */
`timescale 1ns / 1ps

module c_subset_tokenizer_unit_test;
  import ctok_pkg::*;

  // run length
  localparam int RandomItems = 640;
  localparam int DrainCycles = 16;
  localparam int unsigned CycleLimit = 200_000;

  // one row of the directed table; a typed row carries its token as read off by hand
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t tok;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      out_stall = 1'b0;
  wire logic in_stall;
  wire logic out_valid;
  out_item_t out_item;

  int          err_count = 0;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  // tokens the block still owes, oldest first
  out_item_t tokens_due [$];
  // tokens caused by the item just scanned
  out_item_t step_tokens [$];
  plan_row_t plan_rows [$];
  in_item_t  frag [$];

  // lexer state of the predictor
  logic [1:0]          lex_mode;
  logic [7:0]          lex_op_char;
  logic [PosBits-1:0]  tok_start, tok_line, tok_col;
  logic [PosBits-1:0]  pos_offset, pos_line, pos_col;
  logic [3:0]          kw_alive;
  logic [2:0]          id_len;

  string kw_spell [4] = '{"int", "return", "if", "while"};
  logic [KindBits-1:0] kw_kind [4] = '{KIND_INT, KIND_RETURN, KIND_IF, KIND_WHILE};
  logic [7:0] blank_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  string lead_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digit_chars = "0123456789";
  string pair_ops = "==&&||!=";
  string single_ops = "+-*/=<>!;(){}&|";

  c_subset_tokenizer_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // predictor: byte classes, saturating positions, keyword tracking
  // ---------------------------------------------------------------------------------

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic bit space_byte(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit word_byte(logic [7:0] c);
    return alpha_byte(c) || digit_byte(c) || c == "_";
  endfunction

  function automatic logic [PosBits-1:0] bump(logic [PosBits-1:0] v);
    return (v == PosMax) ? PosMax : v + PosOne;
  endfunction

  // only a newline moves to the next line
  function automatic void step_pos(logic [7:0] c);
    pos_offset = bump(pos_offset);
    if (c == 8'h0A) begin
      pos_line = bump(pos_line);
      pos_col  = PosOne;
    end else begin
      pos_col = bump(pos_col);
    end
  endfunction

  function automatic void lex_restart();
    lex_mode    = MODE_IDLE;
    lex_op_char = '0;
    tok_start   = '0;
    tok_line    = PosOne;
    tok_col     = PosOne;
    pos_offset  = '0;
    pos_line    = PosOne;
    pos_col     = PosOne;
    kw_alive    = '1;
    id_len      = '0;
  endfunction

  function automatic void mark_start();
    tok_start = pos_offset;
    tok_line  = pos_line;
    tok_col   = pos_col;
  endfunction

  function automatic void add_token(logic [KindBits-1:0] kind, logic [PosBits-1:0] start,
                                    logic [PosBits-1:0] len, logic [PosBits-1:0] line,
                                    logic [PosBits-1:0] col);
    out_item_t t;
    t.token_kind    = kind;
    t.start_offset  = start;
    t.token_length  = len;
    t.line_number   = line;
    t.column_number = col;
    t.last          = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic logic [KindBits-1:0] single_kind(logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      "/": return KIND_SLASH;
      "=": return KIND_ASSIGN;
      "<": return KIND_LT;
      ">": return KIND_GT;
      "!": return KIND_NOT;
      ";": return KIND_SEMI;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] word_kind();
    for (int k = 0; k < 4; k++) begin
      if (kw_alive[k] && id_len == kw_spell[k].len()) return kw_kind[k];
    end
    return KIND_IDENT;
  endfunction

  // drop every keyword that the next identifier byte rules out
  function automatic void word_take(logic [7:0] c);
    for (int k = 0; k < 4; k++) begin
      if (id_len >= kw_spell[k].len() || kw_spell[k][id_len] != c) kw_alive[k] = 1'b0;
    end
    if (id_len < 3'd7) id_len++;
  endfunction

  // emit the token that is still open, if any
  function automatic void close_pending();
    logic [PosBits-1:0] len;
    len = pos_offset - tok_start;
    case (lex_mode)
      MODE_NUM:   add_token(KIND_LIT, tok_start, len, tok_line, tok_col);
      MODE_IDENT: add_token(word_kind(), tok_start, len, tok_line, tok_col);
      MODE_OP:    add_token(single_kind(lex_op_char), tok_start, PosOne, tok_line, tok_col);
      default: ;
    endcase
    lex_mode = MODE_IDLE;
  endfunction

  // scan one item; its tokens land in step_tokens, the final one flagged last
  function automatic void lex_step(in_item_t it);
    logic [7:0]          c;
    logic [KindBits-1:0] pair_kind;
    bit                  paired;
    c = it.ch;
    paired = 1'b0;
    pair_kind = KIND_UNKNOWN;
    step_tokens.delete();
    if (it.end_of_input) begin
      // flush, end token, then everything starts over
      close_pending();
      add_token(KIND_END, pos_offset, '0, pos_line, pos_col);
      lex_restart();
    end else if (lex_mode == MODE_NUM && digit_byte(c)) begin
      step_pos(c);
    end else if (lex_mode == MODE_IDENT && word_byte(c)) begin
      word_take(c);
      step_pos(c);
    end else begin
      if (lex_mode == MODE_OP) begin
        paired = 1'b1;
        if (lex_op_char == "=" && c == "=") pair_kind = KIND_EQ2;
        else if (lex_op_char == "&" && c == "&") pair_kind = KIND_AND2;
        else if (lex_op_char == "|" && c == "|") pair_kind = KIND_OR2;
        else if (lex_op_char == "!" && c == "=") pair_kind = KIND_NE2;
        else paired = 1'b0;
      end
      if (paired) begin
        add_token(pair_kind, tok_start, PosBits'(2), tok_line, tok_col);
        lex_mode = MODE_IDLE;
      end else begin
        close_pending();
        if (space_byte(c)) begin
          // skipped, only moves the position
        end else if (digit_byte(c)) begin
          mark_start();
          lex_mode = MODE_NUM;
        end else if (alpha_byte(c) || c == "_") begin
          mark_start();
          lex_mode = MODE_IDENT;
          kw_alive = '1;
          id_len   = '0;
          word_take(c);
        end else if (c == "=" || c == "&" || c == "|" || c == "!") begin
          // may still pair with the next byte
          mark_start();
          lex_mode    = MODE_OP;
          lex_op_char = c;
        end else begin
          add_token(single_kind(c), pos_offset, PosOne, pos_line, pos_col);
        end
      end
      step_pos(c);
    end
    if (step_tokens.size() != 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------------

  function automatic out_item_t want(logic [KindBits-1:0] kind, logic [PosBits-1:0] start,
                                     logic [PosBits-1:0] len, logic [PosBits-1:0] line,
                                     logic [PosBits-1:0] col);
    out_item_t t;
    t.token_kind    = kind;
    t.start_offset  = start;
    t.token_length  = len;
    t.line_number   = line;
    t.column_number = col;
    t.last          = 1'b1;
    return t;
  endfunction

  function automatic void plan(logic [7:0] ch, logic eoi, int reps, bit typed,
                               out_item_t tok);
    plan_row_t row;
    row.item.ch           = ch;
    row.item.end_of_input = eoi;
    row.reps              = reps;
    row.typed             = typed;
    row.tok               = tok;
    plan_rows.insert(plan_rows.size(), row);
  endfunction

  function automatic void plan_text(string s);
    for (int j = 0; j < s.len(); j++) plan(s[j], 1'b0, 1, 1'b0, '0);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_char(logic [7:0] c);
    in_item_t it;
    it.ch = c;
    it.end_of_input = 1'b0;
    frag.insert(frag.size(), it);
  endfunction

  function automatic void push_text(string s);
    for (int j = 0; j < s.len(); j++) push_char(s[j]);
  endfunction

  // one lexeme of C-like text, sometimes glued to the next, sometimes noise
  function automatic void make_fragment();
    int       r;
    int       n;
    string    kw;
    in_item_t it;
    frag.delete();
    r = $urandom_range(0, 99);
    if (r < 14) begin
      push_text(kw_spell[$urandom_range(0, 3)]);
    end else if (r < 30) begin
      if ($urandom_range(0, 2) == 0) begin
        // near misses of a keyword: one byte short or one byte long
        kw = kw_spell[$urandom_range(0, 3)];
        if ($urandom_range(0, 1) != 0) begin
          push_text(kw.substr(0, kw.len() - 2));
        end else begin
          push_text(kw);
          push_char(pick(word_chars));
        end
      end else begin
        push_char(pick(lead_chars));
        n = $urandom_range(0, 11);
        repeat (n) push_char(pick(word_chars));
      end
    end else if (r < 42) begin
      n = $urandom_range(1, 6);
      repeat (n) push_char(pick(digit_chars));
    end else if (r < 52) begin
      n = $urandom_range(0, 3);
      push_text(pair_ops.substr(2 * n, 2 * n + 1));
    end else if (r < 70) begin
      push_char(pick(single_ops));
    end else if (r < 82) begin
      n = $urandom_range(1, 3);
      repeat (n) push_char(blank_bytes[$urandom_range(0, 5)]);
    end else begin
      push_char(8'($urandom_range(0, 255)));
    end
    // separator, or none so that neighbors close each other
    r = $urandom_range(0, 3);
    if (r == 0) push_char(8'h20);
    else if (r == 1) push_char(8'h0A);
    // now and then the text ends
    if ($urandom_range(0, 39) == 0) begin
      it.ch = 8'($urandom_range(0, 255));
      it.end_of_input = 1'b1;
      frag.insert(frag.size(), it);
    end
  endfunction

  // drive one item, wait for it to be taken, then record what it owes
  task automatic send_item(input in_item_t it, input bit paced, input bit typed,
                           input out_item_t tok);
    int gap;
    gap = 0;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_step(it);
    if (typed) begin
      tokens_due.insert(tokens_due.size(), tok);
    end else begin
      foreach (step_tokens[k]) tokens_due.insert(tokens_due.size(), step_tokens[k]);
    end
  endtask

  task automatic check_token(input out_item_t exp_tok, input out_item_t got);
    if (got.token_kind !== exp_tok.token_kind) begin
      $error("token_kind: expected %0d, got %0d", exp_tok.token_kind, got.token_kind);
      err_count++;
    end
    if (got.start_offset !== exp_tok.start_offset) begin
      $error("start_offset: expected %0d, got %0d", exp_tok.start_offset, got.start_offset);
      err_count++;
    end
    if (got.token_length !== exp_tok.token_length) begin
      $error("token_length: expected %0d, got %0d", exp_tok.token_length, got.token_length);
      err_count++;
    end
    if (got.line_number !== exp_tok.line_number) begin
      $error("line_number: expected %0d, got %0d", exp_tok.line_number, got.line_number);
      err_count++;
    end
    if (got.column_number !== exp_tok.column_number) begin
      $error("column_number: expected %0d, got %0d", exp_tok.column_number,
             got.column_number);
      err_count++;
    end
    if (got.last !== exp_tok.last) begin
      $error("last: expected %0d, got %0d", exp_tok.last, got.last);
      err_count++;
    end
  endtask

  // ---------------------------------------------------------------------------------
  // token sink: compare every taken token, then pick the next stall
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    out_item_t exp_tok;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        $error("token with nothing expected: kind %0d, offset %0d",
               out_item.token_kind, out_item.start_offset);
        err_count++;
      end else begin
        exp_tok = tokens_due.pop_front();
        check_token(exp_tok, out_item);
      end
    end
    // stall pattern: free run, coin flips, slow toggling, mostly blocked
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= $urandom_range(0, 1) != 0;
      2:       out_stall <= ($urandom_range(0, 3) == 0) ? !out_stall : out_stall;
      default: out_stall <= $urandom_range(0, 3) != 0;
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    bit paused;
    sent = 0;
    paused = 1'b0;
    lex_restart();

    // fresh after reset: offset zero, line one, column one
    plan("+", 1'b0, 1, 1'b1, want(KIND_PLUS, '0, PosOne, PosOne, PosOne));
    plan(8'h00, 1'b1, 1, 1'b1, want(KIND_END, PosOne, '0, PosOne, PosBits'(2)));
    // end right after end, and high or zero bytes as unknown tokens
    plan(8'hFF, 1'b1, 1, 1'b1, want(KIND_END, '0, '0, PosOne, PosOne));
    plan(8'h80, 1'b0, 1, 1'b1, want(KIND_UNKNOWN, '0, PosOne, PosOne, PosOne));
    plan(8'hFF, 1'b0, 1, 1'b1, want(KIND_UNKNOWN, PosOne, PosOne, PosOne, PosBits'(2)));
    plan(8'h00, 1'b0, 1, 1'b1,
         want(KIND_UNKNOWN, PosBits'(2), PosOne, PosOne, PosBits'(3)));
    // lone & and |, = and ! closed by other bytes, every whitespace byte
    plan_text("x&|=!");
    plan(8'h09, 1'b0, 1, 1'b0, '0);
    plan(8'h0B, 1'b0, 1, 1'b0, '0);
    plan(8'h0C, 1'b0, 1, 1'b0, '0);
    plan(8'h0D, 1'b0, 1, 1'b0, '0);
    plan(8'h0A, 1'b0, 1, 1'b0, '0);
    // literal closed by an operator: two tokens from one item
    plan_text(" 9+_");
    // end flushes the open identifier, two tokens again
    plan(8'h41, 1'b1, 1, 1'b0, '0);
    // run of blanks with no gaps, then an identifier closed by punctuation
    plan(" ", 1'b0, 40, 1'b0, '0);
    plan_text("ab;");
    plan(8'h0A, 1'b0, 1, 1'b0, '0);
    plan("+", 1'b0, 1, 1'b1, want(KIND_PLUS, PosBits'(44), PosOne, PosBits'(2), PosOne));
    plan(8'h00, 1'b1, 1, 1'b1,
         want(KIND_END, PosBits'(45), '0, PosBits'(2), PosBits'(2)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; repeated rows go without gaps
    foreach (plan_rows[i]) begin
      for (int n = 0; n < plan_rows[i].reps; n++) begin
        send_item(plan_rows[i].item, plan_rows[i].reps == 1, plan_rows[i].typed,
                  plan_rows[i].tok);
      end
    end

    // random C-like text
    while (sent < RandomItems) begin
      make_fragment();
      foreach (frag[j]) begin
        send_item(frag[j], 1'b1, 1'b0, '0);
        sent++;
      end
      if (!paused && sent >= RandomItems / 2) begin
        // hold off until every owed token is out
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (tokens_due.size() != 0);
      end
    end

    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0 && tokens_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ctok_pkg.sv
hdl/ctok_lexer.sv
hdl/c_subset_tokenizer_unit.sv
dv/c_subset_tokenizer_unit_test.sv
